// ----- src/tofhdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofhdr_pkg
// Shared types, constants and the row-pair selection function of the
// time-of-flight HDR row-pair merge.
// ----------------------------------------------------------------------------
package tofhdr_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LaneN   = 2;   // lane 0: top row, lane 1: bottom row

  // Phase value that maps to max_distance.
  localparam int unsigned PhaseFullScale = 30000;

  // Scaling: q = (max_distance * d) / 30000, saturated at 16 bits.
  localparam int unsigned ProdW    = 2 * DataW;
  // Products at or above this give a quotient that no longer fits 16 bits.
  localparam logic [ProdW-1:0] SatLimit = ProdW'(64'd65536 * PhaseFullScale);
  // p / 30000 == (p >> 4) / 1875. Unsaturated p is below 2^31, so 27 bits.
  localparam int unsigned PreShift   = 4;
  localparam int unsigned DivInW     = 27;
  // ceil(2^38 / 1875); error term 1181 * 2^27 < 2^38, so exact over 27 bits.
  localparam int unsigned RecipShift = 38;
  localparam int unsigned RecipW     = 28;
  localparam logic [RecipW-1:0] Recip = 28'd146601551;
  localparam int unsigned RecipProdW = DivInW + RecipW;

  // Register reset values.
  localparam logic             RstAmpMode = 1'b1;
  localparam logic             RstHdrEn   = 1'b0;
  localparam logic [DataW-1:0] RstAmpThr  = 16'd2000;
  localparam logic [DataW-1:0] RstDistThr = 16'd12500;
  localparam logic [DataW-1:0] RstMaxDist = 16'd12500;
  localparam logic [DataW-1:0] RstValidLim = 16'd64000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AMP_MODE   = 3'd0,
    REG_HDR_EN     = 3'd1,
    REG_AMP_THR    = 3'd2,
    REG_DIST_THR   = 3'd3,
    REG_MAX_DIST   = 3'd4,
    REG_VALID_LIM  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic             amp_mode;
    logic             hdr_en;
    logic [DataW-1:0] amp_thr;
    logic [DataW-1:0] dist_thr;
    logic [DataW-1:0] max_dist;
    logic [DataW-1:0] valid_lim;
  } cfg_t;

  typedef struct packed {
    logic [LaneN-1:0][DataW-1:0] distance;
    logic [LaneN-1:0][DataW-1:0] amp;
    logic                        last;
  } pair_t;

  // True when the bottom pixel wins against threshold t.
  function automatic logic bottom_wins(input logic [DataW-1:0] a,
                                       input logic [DataW-1:0] b,
                                       input logic [DataW-1:0] t);
    logic res;
    if (a < t && b < t) begin
      res = (b > a);
    end else if (a >= t && b <= t) begin
      res = 1'b1;
    end else if (a <= t && b >= t) begin
      res = 1'b0;
    end else begin
      res = !(b < a);
    end
    return res;
  endfunction

endpackage

// ----- src/tofhdr_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofhdr_select
// First stage: when HDR is enabled, picks the winning pixel of a row pair and copies it over.
// ----------------------------------------------------------------------------
module tofhdr_select (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tofhdr_pkg::cfg_t  cfg_i,
  input  logic              in_valid_i,
  input  tofhdr_pkg::pair_t pair_i,
  output logic              out_valid_o,
  output tofhdr_pkg::pair_t pair_o
);
  import tofhdr_pkg::*;

  logic [DataW-1:0] cmp_top;
  logic [DataW-1:0] cmp_bot;
  logic [DataW-1:0] cmp_thr;
  logic             bot_win;
  pair_t            pair_d;
  pair_t            pair_q;
  logic             valid_q;

  always_comb begin
    cmp_top = cfg_i.amp_mode ? pair_i.amp[0] : pair_i.distance[0];
    cmp_bot = cfg_i.amp_mode ? pair_i.amp[1] : pair_i.distance[1];
    cmp_thr = cfg_i.amp_mode ? cfg_i.amp_thr : cfg_i.dist_thr;
    bot_win = bottom_wins(cmp_top, cmp_bot, cmp_thr);
  end

  always_comb begin
    pair_d = pair_i;
    if (cfg_i.hdr_en) begin
      if (bot_win) begin
        pair_d.distance[0] = pair_i.distance[1];
        if (cfg_i.amp_mode) begin
          pair_d.amp[0] = pair_i.amp[1];
        end
      end else begin
        pair_d.distance[1] = pair_i.distance[0];
        if (cfg_i.amp_mode) begin
          pair_d.amp[1] = pair_i.amp[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  assign out_valid_o = valid_q;
  assign pair_o      = pair_q;

endmodule

// ----- src/tofhdr_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofhdr_scale
// Three-stage phase-to-distance scaling of both lanes:
// multiply by max_distance, divide by 30000 via reciprocal, saturate; status codes at or above valid_limit pass.
// ----------------------------------------------------------------------------
module tofhdr_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tofhdr_pkg::cfg_t  cfg_i,
  input  logic              in_valid_i,
  input  tofhdr_pkg::pair_t pair_i,
  output logic              out_valid_o,
  output tofhdr_pkg::pair_t pair_o
);
  import tofhdr_pkg::*;

  // stage A: max_distance * d
  logic                  a_valid_q;
  pair_t                 a_pair_q;
  logic [ProdW-1:0]      a_prod_d [LaneN];
  logic [ProdW-1:0]      a_prod_q [LaneN];
  logic [LaneN-1:0]      a_byp_d;
  logic [LaneN-1:0]      a_byp_q;
  // stage B: reciprocal multiply, saturation flag
  logic                  b_valid_q;
  pair_t                 b_pair_q;
  logic [RecipProdW-1:0] b_recip_d [LaneN];
  logic [RecipProdW-1:0] b_recip_q [LaneN];
  logic [LaneN-1:0]      b_sat_d;
  logic [LaneN-1:0]      b_sat_q;
  logic [LaneN-1:0]      b_byp_q;
  // stage C: final select
  logic                  c_valid_q;
  pair_t                 c_pair_d;
  pair_t                 c_pair_q;

  always_comb begin
    for (int l = 0; l < LaneN; l++) begin
      a_prod_d[l] = ProdW'(cfg_i.max_dist) * ProdW'(pair_i.distance[l]);
      a_byp_d[l]  = (pair_i.distance[l] >= cfg_i.valid_lim);
    end
  end

  always_comb begin
    for (int l = 0; l < LaneN; l++) begin
      b_sat_d[l]   = (a_prod_q[l] >= SatLimit);
      b_recip_d[l] = RecipProdW'(a_prod_q[l][PreShift +: DivInW]) * RecipProdW'(Recip);
    end
  end

  always_comb begin
    c_pair_d = b_pair_q;
    for (int l = 0; l < LaneN; l++) begin
      if (b_byp_q[l]) begin
        c_pair_d.distance[l] = b_pair_q.distance[l];
      end else if (b_sat_q[l]) begin
        c_pair_d.distance[l] = '1;
      end else begin
        c_pair_d.distance[l] = b_recip_q[l][RecipShift +: DataW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_pair_q <= pair_i;
    a_byp_q  <= a_byp_d;
    a_prod_q <= a_prod_d;
    b_pair_q <= a_pair_q;
    b_byp_q  <= a_byp_q;
    b_sat_q  <= b_sat_d;
    b_recip_q <= b_recip_d;
    c_pair_q <= c_pair_d;
  end

  assign out_valid_o = c_valid_q;
  assign pair_o      = c_pair_q;

endmodule

// ----- src/tof_hdr_row_pair_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_hdr_row_pair_merge
// Time-of-flight HDR row-pair merge with phase-to-distance scaling.
// ----------------------------------------------------------------------------
// One pixel pair (top and bottom row of one column) is taken per clock
// whenever start is high; busy is always low, so a pair can be issued every
// cycle. Each request yields exactly one result, shown on the output ports
// for one cycle with valid_o high; the receiver cannot stall, so results
// must be taken when valid_o strobes. A result passes the pipeline registers
// in order: row-pair selection, the max_distance multiply, the
// reciprocal multiply that divides by 30000, and the output register.
// Registers (cfg_we_i/cfg_idx_i/cfg_wdata_i) should be written only while no
// request is in flight; they feed selection and the first scale stage directly.
//
// Behavior:
//  - hdr_enable=1: a compare value per pixel is chosen (amplitude in
//    amplitude mode, raw distance otherwise) and tested against its
//    threshold. Both below: larger wins. One at/above, other at/below: the
//    at/below one wins (bottom wins a tie at the threshold). Both above:
//    larger wins (bottom wins a tie). The winner's distance goes to both pixels; its amplitude
//    too in amplitude mode.
//  - Any distance below valid_limit becomes max_distance*d/30000, clipped at
//    65535; distances at or above valid_limit are status codes and pass.
//  - frame_end_o copies last_pair_i of the same request.
// ----------------------------------------------------------------------------
module tof_hdr_row_pair_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // register write port
  input  logic                           cfg_we_i,
  input  logic [tofhdr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tofhdr_pkg::DataW-1:0]   cfg_wdata_i,
  // request
  input  logic                           start,
  output logic                           busy,
  input  logic [tofhdr_pkg::DataW-1:0]   top_distance_i,
  input  logic [tofhdr_pkg::DataW-1:0]   bottom_distance_i,
  input  logic [tofhdr_pkg::DataW-1:0]   top_amplitude_i,
  input  logic [tofhdr_pkg::DataW-1:0]   bottom_amplitude_i,
  input  logic                           last_pair_i,
  // result
  output logic                           valid_o,
  output logic [tofhdr_pkg::DataW-1:0]   top_distance_out_o,
  output logic [tofhdr_pkg::DataW-1:0]   bottom_distance_out_o,
  output logic [tofhdr_pkg::DataW-1:0]   top_amplitude_out_o,
  output logic [tofhdr_pkg::DataW-1:0]   bottom_amplitude_out_o,
  output logic                           frame_end_o
);
  import tofhdr_pkg::*;

  cfg_t  cfg_q;
  cfg_t  cfg_d;
  pair_t in_pair;
  logic  in_valid;
  logic  sel_valid;
  pair_t sel_pair;
  logic  out_valid;
  pair_t out_pair;

  // --- configuration registers --------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_AMP_MODE:  cfg_d.amp_mode  = cfg_wdata_i[0];
        REG_HDR_EN:    cfg_d.hdr_en    = cfg_wdata_i[0];
        REG_AMP_THR:   cfg_d.amp_thr   = cfg_wdata_i;
        REG_DIST_THR:  cfg_d.dist_thr  = cfg_wdata_i;
        REG_MAX_DIST:  cfg_d.max_dist  = cfg_wdata_i;
        REG_VALID_LIM: cfg_d.valid_lim = cfg_wdata_i;
        default:       cfg_d = cfg_q;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amp_mode  <= RstAmpMode;
      cfg_q.hdr_en    <= RstHdrEn;
      cfg_q.amp_thr   <= RstAmpThr;
      cfg_q.dist_thr  <= RstDistThr;
      cfg_q.max_dist  <= RstMaxDist;
      cfg_q.valid_lim <= RstValidLim;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // --- request intake: fully pipelined, never busy -------------------------
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  always_comb begin
    in_pair.distance[0] = top_distance_i;
    in_pair.distance[1] = bottom_distance_i;
    in_pair.amp[0]      = top_amplitude_i;
    in_pair.amp[1]      = bottom_amplitude_i;
    in_pair.last        = last_pair_i;
  end

  // stage 1: winner selection and copy
  tofhdr_select u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid),
    .pair_i      (in_pair),
    .out_valid_o (sel_valid),
    .pair_o      (sel_pair)
  );

  // stages 2-4: distance scaling with saturation
  tofhdr_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (sel_valid),
    .pair_i      (sel_pair),
    .out_valid_o (out_valid),
    .pair_o      (out_pair)
  );

  // --- result ports (registered inside the scaler) -------------------------
  assign valid_o                = out_valid;
  assign top_distance_out_o     = out_pair.distance[0];
  assign bottom_distance_out_o  = out_pair.distance[1];
  assign top_amplitude_out_o    = out_pair.amp[0];
  assign bottom_amplitude_out_o = out_pair.amp[1];
  assign frame_end_o            = out_pair.last;

endmodule

// ----- src/tofhdr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofhdr_checker
// Port-level checks of the row-pair merge, bound to the top level.
// ----------------------------------------------------------------------------
module tofhdr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [tofhdr_pkg::DataW-1:0]   top_amplitude_i,
  input logic [tofhdr_pkg::DataW-1:0]   bottom_amplitude_i,
  input logic                           last_pair_i,
  input logic                           valid_o,
  input logic [tofhdr_pkg::DataW-1:0]   top_amplitude_out_o,
  input logic [tofhdr_pkg::DataW-1:0]   bottom_amplitude_out_o,
  input logic                           frame_end_o
);
  import tofhdr_pkg::*;

  // every request gives exactly one result
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(start && !busy && rst_ni, 4))
    else $error("result strobe does not match request four cycles earlier");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (frame_end_o == $past(last_pair_i, 4)))
    else $error("frame_end does not follow last_pair of its request");

  // merged amplitudes always come from one of the pair's own amplitudes
  a_amp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((top_amplitude_out_o == $past(top_amplitude_i, 4) ||
                  top_amplitude_out_o == $past(bottom_amplitude_i, 4)) &&
                 (bottom_amplitude_out_o == $past(top_amplitude_i, 4) ||
                  bottom_amplitude_out_o == $past(bottom_amplitude_i, 4))))
    else $error("amplitude result not taken from its own pixel pair");

endmodule

bind tof_hdr_row_pair_merge tofhdr_checker u_tofhdr_checker (.*);

// ----- verif/tof_hdr_row_pair_merge_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_hdr_row_pair_merge_tb
// Self-checking bench for the time-of-flight row-pair HDR merge. Pixel pairs
// are pushed through the command port with random gaps, every result strobe
// is compared field by field against an in-bench model of the selection and
// distance scaling, and the register set is changed between idle phases.
// ----------------------------------------------------------------------------
module tof_hdr_row_pair_merge_tb;
  import tofhdr_pkg::*;

  // Cycles with neither a request nor a result before the run is called hung.
  localparam int IdleLimit  = 400;
  // Cap on printed mismatch lines; further ones are still counted.
  localparam int MaxReports = 40;
  localparam int Phases     = 16;
  localparam int PhaseItems = 100;

  // --------------------------------------------------------------------------
  // Scoreboard: holds a copy of the registers and the queue of merged pairs
  // still owed by the pipeline.
  // --------------------------------------------------------------------------
  class merge_scoreboard;
    cfg_t  regs;
    pair_t owed_pairs[$];
    int    errors;

    function void load_config(cfg_t c);
      regs = c;
    endfunction

    function int pending();
      return owed_pairs.size();
    endfunction

    function void flag(string msg);
      if (errors < MaxReports) $display("%0t ns: %s", $time, msg);
      errors++;
    endfunction

    // Bottom row takes the pair? a = top value, b = bottom value.
    // Ties at the threshold go to the bottom row.
    function logic bottom_takes(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                logic [DataW-1:0] t);
      if (a < t && b < t) return b > a;     // both dark: brighter wins
      if (a > t && b > t) return b >= a;    // both saturated: brighter wins
      return (a >= t && b <= t);            // straddling: the one at/below
    endfunction

    // Raw phase to distance, status codes at or above the limit untouched.
    function logic [DataW-1:0] phase_to_dist(logic [DataW-1:0] d);
      longint unsigned q;
      if (d >= regs.valid_lim) return d;
      q = regs.max_dist;
      q = q * d / PhaseFullScale;
      return (q > 64'hFFFF) ? {DataW{1'b1}} : q[DataW-1:0];
    endfunction

    function pair_t merged_pair(pair_t p);
      pair_t r;
      logic  w;
      r = p;
      if (regs.hdr_en) begin
        w = regs.amp_mode ? bottom_takes(p.amp[0], p.amp[1], regs.amp_thr)
                          : bottom_takes(p.distance[0], p.distance[1], regs.dist_thr);
        r.distance[0] = p.distance[w];
        r.distance[1] = p.distance[w];
        if (regs.amp_mode) begin
          r.amp[0] = p.amp[w];
          r.amp[1] = p.amp[w];
        end
      end
      r.distance[0] = phase_to_dist(r.distance[0]);
      r.distance[1] = phase_to_dist(r.distance[1]);
      return r;
    endfunction

    function void note_request(pair_t p);
      owed_pairs.push_back(merged_pair(p));
    endfunction

    function void compare_field(string name, logic [DataW-1:0] want,
                                logic [DataW-1:0] got);
      if (want !== got)
        flag($sformatf("%s mismatch: expected %h got %h", name, want, got));
    endfunction

    function void check_result(pair_t got);
      pair_t want;
      if (owed_pairs.size() == 0) begin
        flag("result strobe with no request outstanding");
        return;
      end
      want = owed_pairs.pop_front();
      compare_field("top_distance_out",     want.distance[0], got.distance[0]);
      compare_field("bottom_distance_out",  want.distance[1], got.distance[1]);
      compare_field("top_amplitude_out",    want.amp[0],  got.amp[0]);
      compare_field("bottom_amplitude_out", want.amp[1],  got.amp[1]);
      compare_field("frame_end",            DataW'(want.last), DataW'(got.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [DataW-1:0]     cfg_wdata_i;
  logic                 start;
  logic                 busy;
  logic [DataW-1:0]     top_distance_i;
  logic [DataW-1:0]     bottom_distance_i;
  logic [DataW-1:0]     top_amplitude_i;
  logic [DataW-1:0]     bottom_amplitude_i;
  logic                 last_pair_i;
  logic                 valid_o;
  logic [DataW-1:0]     top_distance_out_o;
  logic [DataW-1:0]     bottom_distance_out_o;
  logic [DataW-1:0]     top_amplitude_out_o;
  logic [DataW-1:0]     bottom_amplitude_out_o;
  logic                 frame_end_o;

  tof_hdr_row_pair_merge DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .start                  (start),
    .busy                   (busy),
    .top_distance_i         (top_distance_i),
    .bottom_distance_i      (bottom_distance_i),
    .top_amplitude_i        (top_amplitude_i),
    .bottom_amplitude_i     (bottom_amplitude_i),
    .last_pair_i            (last_pair_i),
    .valid_o                (valid_o),
    .top_distance_out_o     (top_distance_out_o),
    .bottom_distance_out_o  (bottom_distance_out_o),
    .top_amplitude_out_o    (top_amplitude_out_o),
    .bottom_amplitude_out_o (bottom_amplitude_out_o),
    .frame_end_o            (frame_end_o)
  );

  merge_scoreboard sb;
  int              idle_cycles;

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor: all sampling happens on the rising edge, before the NBA updates
  // of that edge, so request and result capture sees settled values.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    pair_t req;
    pair_t res;
    logic  took;
    took = rst_ni && start && !busy;
    if (took) begin
      req.distance[0] = top_distance_i;
      req.distance[1] = bottom_distance_i;
      req.amp[0]      = top_amplitude_i;
      req.amp[1]      = bottom_amplitude_i;
      req.last        = last_pair_i;
      sb.note_request(req);
    end
    // Results can't be held off: check every strobe as it passes.
    if (rst_ni && valid_o) begin
      res.distance[0] = top_distance_out_o;
      res.distance[1] = bottom_distance_out_o;
      res.amp[0]      = top_amplitude_out_o;
      res.amp[1]      = bottom_amplitude_out_o;
      res.last        = frame_end_o;
      sb.check_result(res);
    end
    idle_cycles <= (took || (rst_ni && valid_o)) ? 0 : idle_cycles + 1;
  end

  // Watchdog: nothing moving until idle_cycles reaches IdleLimit means the pipe is stuck.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("%0t ns: no traffic for %0d cycles", $time, IdleLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic cfg_t make_cfg(logic am, logic he, logic [DataW-1:0] at,
                                    logic [DataW-1:0] dt, logic [DataW-1:0] md,
                                    logic [DataW-1:0] vl);
    cfg_t c;
    c.amp_mode  = am;
    c.hdr_en    = he;
    c.amp_thr   = at;
    c.dist_thr  = dt;
    c.max_dist  = md;
    c.valid_lim = vl;
    return c;
  endfunction

  // Threshold-like register value, leaning on the extremes.
  function automatic logic [DataW-1:0] pick_level();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return '1;
      2:       return DataW'($urandom_range(4000, 0));
      default: return DataW'($urandom);
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    logic [DataW-1:0] md;
    logic [DataW-1:0] vl;
    case ($urandom_range(3, 0))
      0:       md = '0;
      1:       md = '1;
      2:       md = RstMaxDist;
      default: md = DataW'($urandom);
    endcase
    case ($urandom_range(3, 0))
      0:       vl = '0;
      1:       vl = '1;
      2:       vl = RstValidLim;
      default: vl = DataW'($urandom);
    endcase
    return make_cfg(1'($urandom_range(1, 0)), $urandom_range(3, 0) != 0,
                    pick_level(), pick_level(), md, vl);
  endfunction

  // Sample clustered on a boundary so ties and off-by-one cases show up often.
  function automatic logic [DataW-1:0] near(logic [DataW-1:0] t);
    case ($urandom_range(7, 0))
      0, 1:    return t;
      2, 3:    return t + DataW'($urandom_range(8, 0)) - DataW'(4);
      4:       return '0;
      5:       return '1;
      default: return DataW'($urandom);
    endcase
  endfunction

  // Mostly back-to-back or short gaps, occasionally a long one.
  function automatic int pick_gap(bit dense);
    int r;
    if (dense) return 0;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Issue one pixel pair and hold it until the block takes it. start stays
  // high when the next request follows with no gap.
  task automatic send_pair(logic [DataW-1:0] td, logic [DataW-1:0] bd,
                           logic [DataW-1:0] ta, logic [DataW-1:0] ba,
                           logic lp, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start              <= 1'b1;
    top_distance_i     <= td;
    bottom_distance_i  <= bd;
    top_amplitude_i    <= ta;
    bottom_amplitude_i <= ba;
    last_pair_i        <= lp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop issuing and let the pipe empty.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [DataW-1:0] val);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Rewrite the whole register set after draining the pipe.
  task automatic write_cfg(cfg_t c);
    drain();
    cfg_we_i <= 1'b1;
    put_reg(REG_AMP_MODE,  DataW'(c.amp_mode));
    put_reg(REG_HDR_EN,    DataW'(c.hdr_en));
    put_reg(REG_AMP_THR,   c.amp_thr);
    put_reg(REG_DIST_THR,  c.dist_thr);
    put_reg(REG_MAX_DIST,  c.max_dist);
    put_reg(REG_VALID_LIM, c.valid_lim);
    cfg_we_i <= 1'b0;
    sb.load_config(c);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stim
    cfg_t             c;
    bit               dense;
    logic [DataW-1:0] td;
    logic [DataW-1:0] bd;
    logic [DataW-1:0] ta;
    logic [DataW-1:0] ba;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_AMP_MODE;
    cfg_wdata_i        <= '0;
    start              <= 1'b0;
    top_distance_i     <= '0;
    bottom_distance_i  <= '0;
    top_amplitude_i    <= '0;
    bottom_amplitude_i <= '0;
    last_pair_i        <= 1'b0;
    sb = new();
    sb.load_config(make_cfg(RstAmpMode, RstHdrEn, RstAmpThr, RstDistThr,
                            RstMaxDist, RstValidLim));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset: HDR off, so distances are only scaled.
    send_pair(16'd30000, 16'd15000, 16'd100, 16'd200, 1'b0, 0);
    send_pair(16'd63999, 16'd64000, 16'd0, 16'hFFFF, 1'b1, 0);

    // Amplitude mode, HDR on, amplitude threshold 2000.
    write_cfg(make_cfg(1'b1, 1'b1, 16'd2000, 16'd12500, 16'd12500, 16'd64000));
    send_pair(16'd100,   16'd200,   16'd500,   16'd1500,  1'b0, 0); // both dark
    send_pair(16'd300,   16'd400,   16'd1500,  16'd500,   1'b0, 0);
    send_pair(16'd500,   16'd600,   16'd700,   16'd700,   1'b0, 1); // dark tie
    send_pair(16'd700,   16'd800,   16'd2500,  16'd1000,  1'b0, 0); // straddle
    send_pair(16'd900,   16'd1000,  16'd2000,  16'd2000,  1'b0, 0); // tie at thr
    send_pair(16'd1100,  16'd1200,  16'd1000,  16'd2000,  1'b0, 2);
    send_pair(16'd0,     16'hFFFF,  16'd5000,  16'd3000,  1'b0, 0); // both bright
    send_pair(16'hFFFF,  16'd0,     16'd3000,  16'd3000,  1'b0, 0);
    send_pair(16'd63999, 16'd64000, 16'hFFFF,  16'd0,     1'b0, 0); // limit edge
    send_pair(16'd64000, 16'd63999, 16'd0,     16'hFFFF,  1'b1, 0);

    // Distance mode: raw distances decide, amplitudes pass untouched.
    write_cfg(make_cfg(1'b0, 1'b1, 16'd2000, 16'd12500, 16'd12500, 16'd64000));
    send_pair(16'd1000,  16'd2000,  16'd11,    16'd22,    1'b0, 0);
    send_pair(16'd12500, 16'd12500, 16'd33,    16'd44,    1'b0, 0);
    send_pair(16'd20000, 16'd13000, 16'hFFFF,  16'd0,     1'b0, 0);
    send_pair(16'd12500, 16'd30000, 16'd0,     16'hFFFF,  1'b1, 0);

    // HDR off, full-scale range: large phases saturate the scaled distance.
    write_cfg(make_cfg(1'b1, 1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
    send_pair(16'd65534, 16'd29999, 16'd1,     16'd2,     1'b1, 0);
    send_pair(16'd30000, 16'd30001, 16'd3,     16'd4,     1'b0, 0);

    // Valid limit zero: every distance is a status code.
    write_cfg(make_cfg(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0));
    send_pair(16'd1234,  16'hFFFF,  16'd10,    16'd20,    1'b0, 0);
    send_pair(16'd0,     16'd5,     16'hFFFF,  16'hFFFF,  1'b1, 0);

    // Random phases. The first two pin the register extremes, every fourth
    // one runs with no gaps at all.
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph == 0)
        c = make_cfg(1'b1, 1'b1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      else if (ph == 1)
        c = make_cfg(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
      else
        c = rand_cfg();
      write_cfg(c);
      dense = (ph % 4 == 3);
      for (int i = 0; i < PhaseItems; i++) begin
        ta = near(c.amp_thr);
        ba = ($urandom_range(7, 0) == 0) ? ta : near(c.amp_thr);
        td = $urandom_range(1, 0) ? near(c.dist_thr) : near(c.valid_lim);
        bd = ($urandom_range(7, 0) == 0) ? td :
             ($urandom_range(1, 0) ? near(c.dist_thr) : near(c.valid_lim));
        send_pair(td, bd, ta, ba, $urandom_range(15, 0) == 0, pick_gap(dense));
        // Now and then hold off until the pipe is empty.
        if ($urandom_range(149, 0) == 0) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
